// ===== rtl/core/ntcc_pkg.sv =====
// ntcc_pkg: shared types and constants for the name tint color cycler.
// Request/response payloads, configuration image, controller commands and status.
// No dependencies.
`timescale 1ns / 1ps

package ntcc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CAPTIONS_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ONE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_TWO      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_THREE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_FOUR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLASH_COLOR      = 3'd5;

	localparam logic [23:0] PALETTE_ONE_RST   = 24'h3D6BDC;
	localparam logic [23:0] PALETTE_TWO_RST   = 24'h800080;
	localparam logic [23:0] PALETTE_THREE_RST = 24'hFFD700;
	localparam logic [23:0] PALETTE_FOUR_RST  = 24'hA00000;
	localparam logic [23:0] FLASH_COLOR_RST   = 24'hC0C0C0;

	// palette slot codes
	localparam logic [7:0] SLOT_ONE   = 8'd1;
	localparam logic [7:0] SLOT_TWO   = 8'd2;
	localparam logic [7:0] SLOT_THREE = 8'd3;
	localparam logic [7:0] SLOT_FOUR  = 8'd4;

	localparam logic [31:0] ID_PHASE_MULT = 32'd37;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_DEFAULT = 2'd1,
		ACT_APPLY   = 2'd2
	} action_t;

	typedef struct packed {
		logic [31:0] entity_id;
		logic [31:0] mode_slots;
		logic        custom_eligible;
		logic        is_target;
	} req_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [23:0] color;
	} rsp_t;

	typedef struct packed {
		logic        captions_enabled;
		logic [23:0] palette_one;
		logic [23:0] palette_two;
		logic [23:0] palette_three;
		logic [23:0] palette_four;
		logic [23:0] flash_color;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_QUOT,
		ST_REM,
		ST_MUL,
		ST_PHASE,
		ST_PROD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    start;
		logic    quot;
		logic    rem;
		logic    mul;
		logic    phase;
		logic    prod;
		logic    div;
		logic    load_out;
		action_t action;
	} cmd_t;

	typedef struct packed {
		logic en_elig;
		logic any_active;
	} sts_t;

endpackage

// ===== rtl/core/ntcc_cfg.sv =====
// ntcc_cfg: configuration register file, written through a plain write port.
// Depends on ntcc_pkg.
`timescale 1ns / 1ps

module ntcc_cfg import ntcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.captions_enabled <= 1'b0;
			cfg_q.palette_one      <= PALETTE_ONE_RST;
			cfg_q.palette_two      <= PALETTE_TWO_RST;
			cfg_q.palette_three    <= PALETTE_THREE_RST;
			cfg_q.palette_four     <= PALETTE_FOUR_RST;
			cfg_q.flash_color      <= FLASH_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAPTIONS_ENABLED: cfg_q.captions_enabled <= cfg_data[0];
				REG_PALETTE_ONE:      cfg_q.palette_one      <= cfg_data;
				REG_PALETTE_TWO:      cfg_q.palette_two      <= cfg_data;
				REG_PALETTE_THREE:    cfg_q.palette_three    <= cfg_data;
				REG_PALETTE_FOUR:     cfg_q.palette_four     <= cfg_data;
				REG_FLASH_COLOR:      cfg_q.flash_color      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/ntcc_ctrl.sv =====
// ntcc_ctrl: sequencing state machine for one request at a time.
// Drives datapath commands and owns request stall and response valid.
// Depends on ntcc_pkg.
`timescale 1ns / 1ps

module ntcc_ctrl import ntcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t  state_q, state_d;
	action_t act_q, act_d;
	logic    rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= ACT_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			act_q   <= act_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		act_d     = act_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				priority if (!sts.en_elig) begin
					act_d   = ACT_NONE;
					state_d = ST_FIN;
				end else if (!sts.any_active) begin
					act_d   = ACT_DEFAULT;
					state_d = ST_FIN;
				end else begin
					act_d     = ACT_APPLY;
					cmd.start = 1'b1;
					state_d   = ST_QUOT;
				end
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PHASE;
			end
			ST_PHASE: begin
				cmd.phase = 1'b1;
				state_d   = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.action = act_q;
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/core/ntcc_dp.sv =====
// ntcc_dp: datapath - slot decode, frame counter, timer remainders, phase split,
// three-channel blend with reciprocal division, response register.
// Depends on ntcc_pkg; sequenced by ntcc_ctrl.
`timescale 1ns / 1ps

module ntcc_dp import ntcc_pkg::*; #(
	parameter int CYCLE_TICKS = 72,
	parameter int FLASH_TICKS = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cfg_t cfg,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	localparam int CW = $clog2(CYCLE_TICKS + 1);
	localparam int FW = $clog2(FLASH_TICKS + 1);
	localparam int QW = CW + 3;
	localparam int NW = CW + 1;
	localparam int AW = NW + 8;
	localparam int PW = 2 * AW + 1;

	localparam logic [FW-1:0] FL_HALF = FW'(FLASH_TICKS / 2);
	localparam logic [QW-1:0] CYC_Q   = QW'(CYCLE_TICKS);
	localparam logic [QW-1:0] C2_Q    = QW'(2 * CYCLE_TICKS);
	localparam logic [QW-1:0] C3_Q    = QW'(3 * CYCLE_TICKS);
	localparam logic [NW-1:0] DEN     = NW'(2 * CYCLE_TICKS);
	localparam logic [31:0]   CYC_32  = 32'(CYCLE_TICKS);
	localparam logic [31:0]   FL_32   = 32'(FLASH_TICKS);

	// floor(x / d) = (x * ceil(2^s / d)) >> s with s = width(x) + ceil(log2 d)
	localparam int SC = 32 + $clog2(CYCLE_TICKS);
	localparam int SF = 32 + $clog2(FLASH_TICKS);
	localparam int SD = AW + $clog2(2 * CYCLE_TICKS);
	localparam logic [32:0] MC =
		33'(((64'd1 << SC) + 64'(CYCLE_TICKS) - 64'd1) / 64'(CYCLE_TICKS));
	localparam logic [32:0] MF =
		33'(((64'd1 << SF) + 64'(FLASH_TICKS) - 64'd1) / 64'(FLASH_TICKS));
	localparam logic [AW:0] MD =
		(AW + 1)'(((64'd1 << SD) + 64'(2 * CYCLE_TICKS) - 64'd1) / 64'(2 * CYCLE_TICKS));

	function automatic logic [23:0] slot_color(input logic [7:0] idx, input cfg_t c);
		logic [23:0] col;
		unique case (idx)
			SLOT_ONE:   col = c.palette_one;
			SLOT_TWO:   col = c.palette_two;
			SLOT_THREE: col = c.palette_three;
			SLOT_FOUR:  col = c.palette_four;
			default:    col = 24'd0;
		endcase
		return col;
	endfunction

	logic [31:0]   frame_q;
	logic [31:0]   id37_q;
	logic [31:0]   slots_q;
	logic          elig_q;
	logic          tgt_q;
	logic [31:0]   tsh_q;
	logic [23:0]   cols_q [4];
	logic [2:0]    n_q;
	logic [31:0]   qc_q;
	logic [31:0]   qf_q;
	logic [CW-1:0] remc_q;
	logic [FW-1:0] remf_q;
	logic [QW-1:0] q_q;
	logic [23:0]   from_q;
	logic [23:0]   to_q;
	logic [NW-1:0] num_q;
	logic [AW-1:0] acc_q [3];
	logic [7:0]    quo_q [3];
	rsp_t          rsp_q;

	// slot decode and compaction of active colors
	logic [23:0] cols_c [4];
	logic [2:0]  n_c;

	always_comb begin : decode
		logic [7:0] idx;
		logic [2:0] cnt;
		cnt = '0;
		for (int i = 0; i < 4; i++) begin
			cols_c[i] = 24'd0;
		end
		for (int i = 0; i < 4; i++) begin
			idx = slots_q[31 - 8 * i -: 8];
			if (idx != 8'd0) begin
				cols_c[cnt[1:0]] = slot_color(idx, cfg);
				cnt              = cnt + 3'd1;
			end
		end
		n_c = cnt;
	end

	assign sts.en_elig    = cfg.captions_enabled & elig_q;
	assign sts.any_active = (n_c != 3'd0);

	// timer quotients by cycle and flash lengths, then remainders
	logic [64:0]   qc_prod;
	logic [64:0]   qf_prod;
	logic [31:0]   qc_c;
	logic [31:0]   qf_c;
	logic [CW-1:0] remc_c;
	logic [FW-1:0] remf_c;

	assign qc_prod = 65'(tsh_q) * 65'(MC);
	assign qf_prod = 65'(tsh_q) * 65'(MF);
	assign qc_c    = 32'(qc_prod >> SC);
	assign qf_c    = 32'(qf_prod >> SF);
	assign remc_c  = CW'(tsh_q - qc_q * CYC_32);
	assign remf_c  = FW'(tsh_q - qf_q * FL_32);

	// phase count P = 2(n-1)
	logic [2:0]    p_c;
	logic [QW-1:0] q_c;

	assign p_c = {n_q[1:0] - 2'd1, 1'b0};
	assign q_c = QW'(remc_q) * QW'(p_c);

	// phase = q / C (below 8), r = q mod C; blend endpoints and ratio numerator
	logic [23:0]   from_c;
	logic [23:0]   to_c;
	logic [NW-1:0] num_c;

	always_comb begin : phase_split
		logic [QW-1:0] qr;
		logic [QW-1:0] dv;
		logic [QW-1:0] r5;
		logic [2:0]    ph;
		logic [1:0]    k;
		logic [23:0]   base;
		logic [23:0]   tgt;
		qr = q_q;
		ph = '0;
		for (int b = 2; b >= 0; b--) begin
			dv = CYC_Q << b;
			if (qr >= dv) begin
				qr    = qr - dv;
				ph[b] = 1'b1;
			end
		end
		r5     = (QW'(qr[CW-1:0]) << 2) + QW'(qr[CW-1:0]);
		k      = ph[2:1] + 2'd1;
		base   = cols_q[0];
		tgt    = cols_q[k];
		from_c = base;
		to_c   = base;
		num_c  = '0;
		if (!ph[0]) begin
			if (r5 >= C3_Q) begin
				to_c  = tgt;
				num_c = NW'(r5 - C3_Q);
			end
		end else if (r5 < C2_Q) begin
			from_c = tgt;
			num_c  = NW'(r5);
		end
	end

	// per-channel numerator a*(D-N) + b*N
	logic [AW-1:0] acc_c [3];

	always_comb begin : blend_prod
		for (int ch = 0; ch < 3; ch++) begin
			acc_c[ch] = AW'(from_q[8 * ch +: 8]) * AW'(DEN - num_q)
				+ AW'(to_q[8 * ch +: 8]) * AW'(num_q);
		end
	end

	// blend quotient by D through reciprocal multiply
	logic [PW-1:0] quo_prod [3];
	logic [7:0]    quo_c [3];

	always_comb begin : blend_div
		for (int ch = 0; ch < 3; ch++) begin
			quo_prod[ch] = PW'(acc_q[ch]) * PW'(MD);
			quo_c[ch]    = 8'(quo_prod[ch] >> SD);
		end
	end

	logic        flash_c;
	logic [23:0] color_c;

	assign flash_c = tgt_q && (remf_q < FL_HALF);

	always_comb begin
		color_c = 24'd0;
		if (cmd.action == ACT_APPLY) begin
			color_c = flash_c ? cfg.flash_color : {quo_q[2], quo_q[1], quo_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (cmd.start) begin
			frame_q <= frame_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id37_q  <= req.entity_id * ID_PHASE_MULT;
			slots_q <= req.mode_slots;
			elig_q  <= req.custom_eligible;
			tgt_q   <= req.is_target;
		end
		if (cmd.start) begin
			tsh_q <= frame_q + 32'd1 + id37_q;
			n_q   <= n_c;
			for (int i = 0; i < 4; i++) begin
				cols_q[i] <= cols_c[i];
			end
		end
		if (cmd.quot) begin
			qc_q <= qc_c;
			qf_q <= qf_c;
		end
		if (cmd.rem) begin
			remc_q <= remc_c;
			remf_q <= remf_c;
		end
		if (cmd.mul) begin
			q_q <= q_c;
		end
		if (cmd.phase) begin
			from_q <= from_c;
			to_q   <= to_c;
			num_q  <= num_c;
		end
		if (cmd.prod) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= acc_c[ch];
			end
		end
		if (cmd.div) begin
			for (int ch = 0; ch < 3; ch++) begin
				quo_q[ch] <= quo_c[ch];
			end
		end
		if (cmd.load_out) begin
			rsp_q.action <= cmd.action;
			rsp_q.color  <= color_c;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/name_tint_color_cycler.sv =====
// name_tint_color_cycler: top level of the name tint color cycler.
// Instantiates ntcc_cfg, ntcc_ctrl and ntcc_dp; depends on ntcc_pkg.
`timescale 1ns / 1ps

// Usage
// req channel (req_valid / req_stall / req) carries one update request:
// entity id, packed palette slots, eligibility and target flag.
// rsp channel (rsp_valid / rsp_stall / rsp) returns one response per request:
// action code and 0xRRGGBB color.
// cfg_we / cfg_index / cfg_data write the six setup registers; write only
// while no request is in flight.
// One request is handled at a time; req_stall is low only while idle.
// From request accept to response valid, a request that is disabled, ineligible
// or has no active slot passes the prep state and the response load; when a color
// is applied it passes slot decode, timer quotients, timer remainders, phase
// multiply, phase split, channel products, blend quotients by reciprocal multiply
// and response load. A new request is taken only after the last one is loaded.
// The response sits in an output register; the next request is taken while it
// waits. A held rsp_stall only blocks the final load of the following response.
// Reset clears the frame counter, the control state and restores register defaults.

module name_tint_color_cycler import ntcc_pkg::*; #(
	parameter int CYCLE_TICKS = 72,
	parameter int FLASH_TICKS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ntcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ntcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ntcc_dp #(
		.CYCLE_TICKS (CYCLE_TICKS),
		.FLASH_TICKS (FLASH_TICKS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid || !rsp_stall))
		else $error("response loaded over a pending response");

	a_color_only_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.action != ACT_APPLY) |-> rsp.color == 24'd0)
		else $error("nonzero color without apply action");

	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in flight");
`endif

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for name_tint_color_cycler; predicts every response from its own
// copy of the setup registers and the frame counter, under random request gaps and stalls.
// Depends on ntcc_pkg and the name_tint_color_cycler RTL.
`timescale 1ns / 1ps

module tb;
	import ntcc_pkg::*;

	localparam int CYCLE_TICKS = 72;
	localparam int FLASH_TICKS = 6;
	localparam int RUN_LIMIT   = 400000;
	localparam int DRAIN_WAIT  = 24;
	localparam int PHASE_REQS  = 212;

	// indexes past the register list; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0]          cfg_data  = '0;

	// shadow of the block's setup and state
	logic        tint_enable;
	logic [23:0] pal_one, pal_two, pal_three, pal_four, flash_rgb;
	logic [31:0] frame_count;

	rsp_t        tint_expect_q[$];
	rsp_t        tint_want;
	int          mismatch_count = 0;
	int          tints_checked  = 0;
	int          reqs_sent      = 0;
	int          settings_used  = 0;
	int          cycle_count    = 0;
	int          burst_left     = 0;
	bit          pace_on        = 1'b0;
	logic [8:0]  stall_tick     = '0;

	name_tint_color_cycler #(
		.CYCLE_TICKS(CYCLE_TICKS),
		.FLASH_TICKS(FLASH_TICKS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [23:0] blend_rgb(logic [23:0] from, logic [23:0] to,
			int unsigned num, int unsigned den);
		logic [23:0] mixed;
		longint unsigned a, b;
		if (num == 0) return from;
		if (num >= den) return to;
		mixed = '0;
		for (int sh = 0; sh < 24; sh += 8) begin
			a = 64'(from[sh +: 8]);
			b = 64'(to[sh +: 8]);
			mixed[sh +: 8] = 8'((a * (den - num) + b * num) / den);
		end
		return mixed;
	endfunction

	function automatic rsp_t predict_tint(req_t r);
		rsp_t             o;
		logic [3:0][23:0] shades;
		logic [7:0]       code;
		logic [23:0]      hue, tgt, col;
		logic [31:0]      timer;
		int unsigned      n, phases, q, phase, rem;
		o = '0;
		o.action = ACT_NONE;
		n = 0;
		shades = '0;
		if (!tint_enable || !r.custom_eligible) return o;
		for (int i = 0; i < 4; i++) begin
			code = r.mode_slots[31 - 8 * i -: 8];
			if (code != 8'd0) begin
				case (code)
					SLOT_ONE:   hue = pal_one;
					SLOT_TWO:   hue = pal_two;
					SLOT_THREE: hue = pal_three;
					SLOT_FOUR:  hue = pal_four;
					default:    hue = 24'h000000;
				endcase
				shades[n] = hue;
				n++;
			end
		end
		if (n == 0) begin
			o.action = ACT_DEFAULT;
			return o;
		end
		frame_count = frame_count + 32'd1;
		timer = frame_count + r.entity_id * ID_PHASE_MULT;
		if (n == 1) begin
			col = shades[0];
		end else begin
			phases = 2 * (n - 1);
			q = (timer % CYCLE_TICKS) * phases;
			phase = q / CYCLE_TICKS;
			rem = q % CYCLE_TICKS;
			tgt = shades[((phase / 2) % (n - 1)) + 1];
			if (phase % 2 == 0) begin
				if (5 * rem < 3 * CYCLE_TICKS) col = shades[0];
				else col = blend_rgb(shades[0], tgt, 5 * rem - 3 * CYCLE_TICKS, 2 * CYCLE_TICKS);
			end else begin
				if (5 * rem < 2 * CYCLE_TICKS) col = blend_rgb(tgt, shades[0], 5 * rem, 2 * CYCLE_TICKS);
				else col = shades[0];
			end
		end
		if (r.is_target && (timer % FLASH_TICKS) < FLASH_TICKS / 2) col = flash_rgb;
		o.action = ACT_APPLY;
		o.color = col;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h (response %0d, t=%0t)",
			what, got, want, tints_checked, $realtime);
		mismatch_count++;
	endtask

	// one request per call; gaps come between bursts when pacing is on
	task automatic send_req(req_t item);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		tint_expect_q.push_back(predict_tint(item));
		reqs_sent++;
		if (pace_on) begin
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (tint_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAPTIONS_ENABLED: tint_enable = data[0];
			REG_PALETTE_ONE:      pal_one = data;
			REG_PALETTE_TWO:      pal_two = data;
			REG_PALETTE_THREE:    pal_three = data;
			REG_PALETTE_FOUR:     pal_four = data;
			REG_FLASH_COLOR:      flash_rgb = data;
			default: ;
		endcase
	endtask

	task automatic load_palette(logic [23:0] p1, logic [23:0] p2, logic [23:0] p3,
			logic [23:0] p4, logic [23:0] fl);
		write_reg(REG_PALETTE_ONE, p1);
		write_reg(REG_PALETTE_TWO, p2);
		write_reg(REG_PALETTE_THREE, p3);
		write_reg(REG_PALETTE_FOUR, p4);
		write_reg(REG_FLASH_COLOR, fl);
		settings_used++;
	endtask

	// response stall: none, sparse random, regular bursts, heavy random
	always @(posedge clk) begin
		stall_tick <= stall_tick + 9'd1;
		case (stall_tick[8:7])
			2'd0:    rsp_stall <= 1'b0;
			2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
			2'd2:    rsp_stall <= (stall_tick[4:3] == 2'b11);
			default: rsp_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (tint_expect_q.size() == 0) begin
				report_mismatch("response with nothing pending", {6'd0, rsp}, 32'd0);
			end else begin
				tint_want = tint_expect_q.pop_front();
				if (rsp.action !== tint_want.action)
					report_mismatch("action", {30'd0, rsp.action}, {30'd0, tint_want.action});
				if (rsp.color !== tint_want.color)
					report_mismatch("color", {8'd0, rsp.color}, {8'd0, tint_want.color});
				tints_checked++;
			end
		end
	end

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d responses outstanding",
			cycle_count, tint_expect_q.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic test_disabled();
		send_req('{32'h0000_0000, 32'h0102_0304, 1'b1, 1'b1});
		send_req('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0});
		send_req('{32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1});
		wait_idle();
	endtask

	task automatic test_special_cases();
		// upper data bits of the enable write are don't-care
		write_reg(REG_CAPTIONS_ENABLED, 24'hFFFFFF);
		send_req('{32'h0000_0005, 32'h0102_0304, 1'b0, 1'b0});
		send_req('{32'h0000_0007, 32'h0000_0000, 1'b1, 1'b1});
		send_req('{32'h0000_0001, 32'h0100_0000, 1'b1, 1'b0});
		send_req('{32'h0000_0002, 32'h0002_0000, 1'b1, 1'b1});
		send_req('{32'h0000_0003, 32'h0000_0300, 1'b1, 1'b0});
		send_req('{32'h0000_0004, 32'h0000_0004, 1'b1, 1'b1});
		send_req('{32'h0000_0009, 32'h0500_00FF, 1'b1, 1'b0});
		send_req('{32'h0000_000B, 32'h0100_0005, 1'b1, 1'b0});
		send_req('{32'hFFFF_FFFF, 32'h0102_0304, 1'b1, 1'b1});
		send_req('{32'h0000_0000, 32'h0102_0304, 1'b1, 1'b0});
		send_req('{32'h8000_0011, 32'h8000_0001, 1'b1, 1'b0});
		wait_idle();
	endtask

	task automatic test_register_writes();
		load_palette(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
		write_reg(REG_SPARE_LO, 24'h123456);
		write_reg(REG_SPARE_HI, 24'hFFFFFF);
		send_req('{32'h0000_0013, 32'h0102_0000, 1'b1, 1'b0});
		send_req('{32'h0000_0021, 32'h0304_0000, 1'b1, 1'b1});
		send_req('{32'h0000_0030, 32'h0201_0403, 1'b1, 1'b1});
		send_req('{32'h7FFF_FFFF, 32'h0000_0201, 1'b1, 1'b0});
		wait_idle();
		write_reg(REG_CAPTIONS_ENABLED, 24'h000000);
		send_req('{32'h0000_0001, 32'h0102_0304, 1'b1, 1'b1});
		wait_idle();
		write_reg(REG_CAPTIONS_ENABLED, 24'h000001);
		load_palette(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
		send_req('{32'h0000_0044, 32'h0102_0304, 1'b1, 1'b1});
		send_req('{32'h0000_0051, 32'h0403_0201, 1'b1, 1'b0});
		send_req('{32'hAAAA_AAAA, 32'h0200_0001, 1'b1, 1'b0});
		wait_idle();
	endtask

	task automatic test_random_phases();
		req_t        item;
		logic [23:0] p [5];
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 5; k++)
				p[k] = (ph == 3) ? ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000)
				                 : 24'($urandom());
			load_palette(p[0], p[1], p[2], p[3], p[4]);
			pace_on = (ph != 1);
			for (int i = 0; i < PHASE_REQS; i++) begin
				item.entity_id = $urandom();
				for (int s = 0; s < 4; s++) begin
					case ($urandom_range(0, 9))
						0, 1:    item.mode_slots[31 - 8 * s -: 8] = 8'd0;
						8:       item.mode_slots[31 - 8 * s -: 8] = 8'($urandom_range(5, 255));
						default: item.mode_slots[31 - 8 * s -: 8] = 8'($urandom_range(1, 4));
					endcase
				end
				item.custom_eligible = ($urandom_range(0, 15) != 0);
				item.is_target = 1'($urandom_range(0, 1));
				send_req(item);
			end
			wait_idle();
		end
		pace_on = 1'b0;
	endtask

	initial begin
		tint_enable = 1'b0;
		pal_one = PALETTE_ONE_RST;
		pal_two = PALETTE_TWO_RST;
		pal_three = PALETTE_THREE_RST;
		pal_four = PALETTE_FOUR_RST;
		flash_rgb = FLASH_COLOR_RST;
		frame_count = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled();
		test_special_cases();
		test_register_writes();
		test_random_phases();

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d requests over %0d palette settings; %0d responses compared",
			reqs_sent, settings_used, tints_checked);
		$display("Mismatches: %0d, responses still pending: %0d",
			mismatch_count, tint_expect_q.size());
		if (mismatch_count == 0 && tint_expect_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
